[src/ppdfb_pkg.sv]
// shared types and constants of the palette pixel doubler
package ppdfb_pkg;

   localparam int PAL_BITS   = 8;
   localparam int BLEND_BITS = 16;
   localparam int COLOR_BITS = 16;
   localparam int OUT_ADDR_BITS = 18;
   localparam int CSR_DATA_BITS = 18;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [COLOR_BITS-1:0] BLEND_MASK = 16'hf7de;

   // item commands
   localparam logic [1:0] CMD_PIXEL    = 2'd0;
   localparam logic [1:0] CMD_PAL_WR   = 2'd1;
   localparam logic [1:0] CMD_BLEND_WR = 2'd2;

   // flicker modes
   localparam logic [1:0] MODE_OFF      = 2'd0;
   localparam logic [1:0] MODE_PHOSPHOR = 2'd1;
   localparam logic [1:0] MODE_AVERAGE  = 2'd2;
   localparam logic [1:0] MODE_SIMPLE   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLICKER_MODE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PREVIOUS_VALID = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_PITCH     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ADDRESS   = 3'd5;

   typedef struct packed {
      logic [8:0]  frame_width;
      logic [8:0]  frame_height;
      logic [11:0] line_pitch;
      logic [17:0] base_address;
   } geom_cfg_type;

   typedef struct packed {
      logic                  rd_en;
      logic                  pal_we;
      logic                  blend_we;
      logic [PAL_BITS-1:0]   pal_a_idx;
      logic [PAL_BITS-1:0]   cur;
      logic [PAL_BITS-1:0]   prev;
      logic [COLOR_BITS-1:0] color;
   } tbl_req_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] pal_a;
      logic [COLOR_BITS-1:0] pal_b;
      logic [COLOR_BITS-1:0] blend;
   } tbl_rd_type;

endpackage

[src/ppdfb_tables.sv]
// palette and blend table memories with registered reads
module ppdfb_tables (
   input  logic                 clock,
   input  ppdfb_pkg::tbl_req_type req,
   output ppdfb_pkg::tbl_rd_type  rd
);
   import ppdfb_pkg::*;

   localparam int BLEND_ENTRIES = 1 << BLEND_BITS;

   logic [COLOR_BITS-1:0] pal_mem_ff [0:(1<<PAL_BITS)-1];
   logic [COLOR_BITS-1:0] blend_mem_ff [0:BLEND_ENTRIES-1];
   logic [COLOR_BITS-1:0] pal_a_ff;
   logic [COLOR_BITS-1:0] pal_b_ff;
   logic [COLOR_BITS-1:0] blend_ff;
   logic [BLEND_BITS-1:0] blend_idx;

   assign blend_idx = {req.cur, req.prev};

   // palette: one write port, two read ports
   always_ff @(posedge clock) begin
      if (req.pal_we) begin
         pal_mem_ff[req.cur] <= req.color;
      end
      if (req.rd_en) begin
         pal_a_ff <= pal_mem_ff[req.pal_a_idx];
         pal_b_ff <= pal_mem_ff[req.prev];
      end
   end

   always_ff @(posedge clock) begin
      if (req.blend_we) begin
         blend_mem_ff[blend_idx] <= req.color;
      end
      if (req.rd_en) begin
         blend_ff <= blend_mem_ff[blend_idx];
      end
   end

   assign rd.pal_a = pal_a_ff;
   assign rd.pal_b = pal_b_ff;
   assign rd.blend = blend_ff;

endmodule

[src/ppdfb_addr.sv]
// column, row and line start counters that form the output address
module ppdfb_addr #(
   parameter int ADDR_BITS = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  ppdfb_pkg::geom_cfg_type cfg,
   output logic [ADDR_BITS-1:0]    addr,
   output logic                    frame_done
);
   import ppdfb_pkg::*;

   logic [7:0]           col_ff, col_in;
   logic [7:0]           row_ff, row_in;
   logic [ADDR_BITS-1:0] row_start_ff, row_start_in;

   logic [ADDR_BITS+17:0] base_wide;
   logic [ADDR_BITS-1:0]  base_a;
   logic [ADDR_BITS-1:0]  row_start_eff;
   logic [8:0]            width_c, height_c;
   logic [8:0]            col_next, row_next;
   logic                  line_end;

   assign base_wide = {{ADDR_BITS{1'b0}}, cfg.base_address};
   assign base_a    = base_wide[ADDR_BITS-1:0];

   // sizes of zero act as one, above 256 as 256
   always_comb begin
      width_c  = (cfg.frame_width == 9'd0) ? 9'd1 :
                 (cfg.frame_width > 9'd256) ? 9'd256 : cfg.frame_width;
      height_c = (cfg.frame_height == 9'd0) ? 9'd1 :
                 (cfg.frame_height > 9'd256) ? 9'd256 : cfg.frame_height;
   end

   // the frame start picks up the base in force now
   assign row_start_eff = (col_ff == 8'd0 && row_ff == 8'd0) ? base_a : row_start_ff;
   assign addr          = row_start_eff + ADDR_BITS'({col_ff, 1'b0});

   assign col_next   = {1'b0, col_ff} + 9'd1;
   assign row_next   = {1'b0, row_ff} + 9'd1;
   assign line_end   = col_next >= width_c;
   assign frame_done = line_end && (row_next >= height_c);

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      row_start_in = row_start_ff;
      if (step) begin
         if (!line_end) begin
            col_in       = col_next[7:0];
            // keep the line start that this pixel used
            row_start_in = row_start_eff;
         end else begin
            col_in = 8'd0;
            if (frame_done) begin
               row_in       = 8'd0;
               row_start_in = base_a;
            end else begin
               row_in       = row_next[7:0];
               row_start_in = row_start_eff + ADDR_BITS'(cfg.line_pitch);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         row_start_ff <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_start_ff <= row_start_in;
      end
   end

endmodule

[src/ppdfb_out.sv]
// read-wait stage, color select and the output buffer for the word pairs
module ppdfb_out #(
   parameter int ADDR_BITS = 18
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pix_acc,
   input  logic [ADDR_BITS-1:0]   pix_addr,
   input  logic                   pix_frame_done,
   input  logic [1:0]             pix_mode,
   input  ppdfb_pkg::tbl_rd_type  rd,
   output logic                   hold,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ppdfb_pkg::OUT_ADDR_BITS-1:0] rsp_write_address,
   output logic [ppdfb_pkg::COLOR_BITS-1:0]    rsp_pixel_color,
   output logic                   rsp_last,
   output logic                   rsp_frame_end
);
   import ppdfb_pkg::*;

   // read-wait stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [ADDR_BITS-1:0] s1_addr_ff;
   logic                 s1_frame_ff;
   logic [1:0]           s1_mode_ff;

   // output buffer
   logic                  ob_valid_ff, ob_valid_in;
   logic                  ob_last_ff, ob_last_in;
   logic [ADDR_BITS-1:0]  ob_addr_ff, ob_addr_in;
   logic [COLOR_BITS-1:0] ob_color_ff, ob_color_in;
   logic                  ob_frame_ff, ob_frame_in;

   logic                  rsp_acc;
   logic                  s1_move;
   logic [COLOR_BITS-1:0] mean;
   logic [COLOR_BITS-1:0] color;
   logic [ADDR_BITS+17:0] out_wide;

   assign rsp_acc = ob_valid_ff && !rsp_stall;
   assign s1_move = s1_valid_ff && (!ob_valid_ff || (ob_last_ff && rsp_acc));
   assign hold    = s1_valid_ff && !s1_move;

   assign mean = (((rd.pal_a ^ rd.pal_b) & BLEND_MASK) >> 1) + (rd.pal_a & rd.pal_b);

   always_comb begin
      case (s1_mode_ff)
         MODE_PHOSPHOR: color = rd.blend;
         MODE_AVERAGE:  color = mean;
         default:       color = rd.pal_a;
      endcase
   end

   assign s1_valid_in = pix_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_comb begin
      ob_valid_in = ob_valid_ff;
      ob_last_in  = ob_last_ff;
      ob_addr_in  = ob_addr_ff;
      ob_color_in = ob_color_ff;
      ob_frame_in = ob_frame_ff;
      if (s1_move) begin
         ob_valid_in = 1'b1;
         ob_last_in  = 1'b0;
         ob_addr_in  = s1_addr_ff;
         ob_color_in = color;
         ob_frame_in = s1_frame_ff;
      end else if (rsp_acc) begin
         if (!ob_last_ff) begin
            ob_last_in = 1'b1;
            ob_addr_in = ob_addr_ff + ADDR_BITS'(1);
         end else begin
            ob_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         ob_valid_ff <= 1'b0;
         ob_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         ob_valid_ff <= ob_valid_in;
         ob_last_ff  <= ob_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_addr_ff  <= pix_addr;
         s1_frame_ff <= pix_frame_done;
         s1_mode_ff  <= pix_mode;
      end
      ob_addr_ff  <= ob_addr_in;
      ob_color_ff <= ob_color_in;
      ob_frame_ff <= ob_frame_in;
   end

   assign out_wide          = {18'd0, ob_addr_ff};
   assign rsp_valid         = ob_valid_ff;
   assign rsp_write_address = out_wide[OUT_ADDR_BITS-1:0];
   assign rsp_pixel_color   = ob_color_ff;
   assign rsp_last          = ob_last_ff;
   assign rsp_frame_end     = ob_frame_ff;

endmodule

[src/palette_pixel_doubler_flicker_blend_top.sv]
// top level of the palette pixel doubler with frame blend
// each pixel word is turned into two rgb565 framebuffer writes at neighboring
// addresses, base + row * pitch + 2 * column, wrapping at 2^ADDR_BITS. a pixel
// word occupies the single result port for both of its writes, and the next
// pixel leaves the read stage only once the buffer is empty or its second
// word is taken. palette and blend table writes give no result. the first
// result word passes through the synchronous table read and then the output
// buffer. both tables hold garbage until written and have no clearing pass.
module palette_pixel_doubler_flicker_blend_top #(
   parameter int ADDR_BITS = 18
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_current_index,
   input  logic [7:0]  req_previous_index,
   input  logic [15:0] req_entry_color,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [17:0] rsp_write_address,
   output logic [15:0] rsp_pixel_color,
   output logic        rsp_last,
   output logic        rsp_frame_end,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic [ppdfb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppdfb_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import ppdfb_pkg::*;

   // configuration registers
   logic [1:0]   flicker_mode_ff;
   logic         previous_valid_ff;
   geom_cfg_type geom_ff;

   logic                 req_acc;
   logic                 pix_acc;
   logic [1:0]           mode_eff;
   logic                 hold;
   logic [ADDR_BITS-1:0] pix_addr;
   logic                 pix_frame_done;
   tbl_req_type          tbl_req;
   tbl_rd_type           tbl_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         flicker_mode_ff           <= MODE_OFF;
         previous_valid_ff         <= 1'b0;
         geom_ff.frame_width       <= 9'd160;
         geom_ff.frame_height      <= 9'd210;
         geom_ff.line_pitch        <= 12'd512;
         geom_ff.base_address      <= 18'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FLICKER_MODE:   flicker_mode_ff      <= csr_write_data[1:0];
            CSR_PREVIOUS_VALID: previous_valid_ff    <= csr_write_data[0];
            CSR_FRAME_WIDTH:    geom_ff.frame_width  <= csr_write_data[8:0];
            CSR_FRAME_HEIGHT:   geom_ff.frame_height <= csr_write_data[8:0];
            CSR_LINE_PITCH:     geom_ff.line_pitch   <= csr_write_data[11:0];
            CSR_BASE_ADDRESS:   geom_ff.base_address <= csr_write_data[17:0];
            default: ;
         endcase
      end
   end

   // input waits only while a pixel sits in the read stage and cannot move on
   assign req_stall = hold;
   assign req_acc   = req_valid && !req_stall;
   assign pix_acc   = req_acc && (req_cmd == CMD_PIXEL);

   // without a previous frame the block behaves as mode off
   assign mode_eff = previous_valid_ff ? flicker_mode_ff : MODE_OFF;

   // table access: writes land at accept, so a following pixel already sees them
   always_comb begin
      tbl_req.rd_en    = pix_acc;
      tbl_req.pal_we   = req_acc && (req_cmd == CMD_PAL_WR);
      tbl_req.blend_we = req_acc && (req_cmd == CMD_BLEND_WR);
      tbl_req.cur      = req_current_index;
      tbl_req.prev     = req_previous_index;
      tbl_req.color    = req_entry_color;
      // simple mode falls back to the previous index on a zero index
      tbl_req.pal_a_idx = (mode_eff == MODE_SIMPLE && req_current_index == 8'd0) ?
                          req_previous_index : req_current_index;
   end

   ppdfb_tables u_tables (
      .clock (clock),
      .req   (tbl_req),
      .rd    (tbl_rd)
   );

   ppdfb_addr #(
      .ADDR_BITS (ADDR_BITS)
   ) u_addr (
      .clock      (clock),
      .reset      (reset),
      .step       (pix_acc),
      .cfg        (geom_ff),
      .addr       (pix_addr),
      .frame_done (pix_frame_done)
   );

   ppdfb_out #(
      .ADDR_BITS (ADDR_BITS)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .pix_acc           (pix_acc),
      .pix_addr          (pix_addr),
      .pix_frame_done    (pix_frame_done),
      .pix_mode          (mode_eff),
      .rd                (tbl_rd),
      .hold              (hold),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last          (rsp_last),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

[src/ppdfb_checker.sv]
// port-level checks on the result stream, bound to the top level
module ppdfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_pixel_color,
   input logic        rsp_last,
   input logic        rsp_frame_end
);

   // a stalled word stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // the second word of a pair follows right after the first is taken
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_last)
      else $error("second word of pair missing");

   // both words of a pair carry the same color and frame end flag
   a_pair_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_pixel_color == $past(rsp_pixel_color) &&
         rsp_frame_end == $past(rsp_frame_end))
      else $error("pair words differ");

   // a new burst of words starts with the first of a pair
   a_start_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> !rsp_last)
      else $error("stream starts on second word");

endmodule

bind palette_pixel_doubler_flicker_blend_top ppdfb_checker u_ppdfb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last        (rsp_last),
   .rsp_frame_end   (rsp_frame_end)
);

[tb/tb_palette_pixel_doubler_flicker_blend_top.sv]
// self-checking testbench for the palette pixel doubler with frame blend
module tb_palette_pixel_doubler_flicker_blend_top;
   import ppdfb_pkg::*;

   // command code the block drops without a result
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // cycles that a table write may still sit in the pipe after the last result
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [17:0] addr;
      logic [15:0] color;
      logic        last;
      logic        frame_end;
   } fb_write_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [7:0]  req_current_index;
   logic [7:0]  req_previous_index;
   logic [15:0] req_entry_color;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [17:0] rsp_write_address;
   logic [15:0] rsp_pixel_color;
   logic        rsp_last;
   logic        rsp_frame_end;
   logic        csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   // framebuffer writes still owed by the block, oldest first
   fb_write_type pending_writes[$];
   int           mismatch_count = 0;

   // shadow of the color tables, plus lists of what has been written so far
   logic [15:0] pal_mem[256];
   bit          pal_written[256];
   logic [7:0]  pal_used[$];
   logic [15:0] blend_mem[logic [15:0]];
   logic [15:0] blend_keys[$];

   // shadow of the registers and of the scan position
   logic [1:0]  cfg_mode;
   logic        cfg_prev_valid;
   logic [8:0]  cfg_width;
   logic [8:0]  cfg_height;
   logic [11:0] cfg_pitch;
   logic [17:0] cfg_base;
   logic [7:0]  scan_col;
   logic [7:0]  scan_row;
   logic [17:0] row_start;

   // sender state: whether valid is up, and words left in the current burst
   bit valid_up = 0;
   int burst_left = 0;
   // long receiver hold-off, picked up by the stall process
   int hold_off_request = 0;

   palette_pixel_doubler_flicker_blend_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_current_index  (req_current_index),
      .req_previous_index (req_previous_index),
      .req_entry_color    (req_entry_color),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_address  (rsp_write_address),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_last           (rsp_last),
      .rsp_frame_end      (rsp_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic void note_error(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endfunction

   // zero acts as one line or pixel, anything past 256 as 256
   function automatic int clamp_size(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   // color pick and address walk for one pixel word, two writes queued
   function automatic void predict_pixel(logic [7:0] cur, logic [7:0] prev);
      logic [1:0]   eff_mode;
      logic [15:0]  color;
      logic [15:0]  pa;
      logic [15:0]  pb;
      logic [17:0]  addr;
      bit           line_end;
      bit           frame_done;
      fb_write_type wr;
      // base is latched at the first pixel of every frame
      if (scan_col == 0 && scan_row == 0) row_start = cfg_base;
      // no previous frame means plain palette lookup
      eff_mode = cfg_prev_valid ? cfg_mode : MODE_OFF;
      pa = pal_mem[cur];
      pb = pal_mem[prev];
      case (eff_mode)
         MODE_PHOSPHOR: color = blend_mem[{cur, prev}];
         MODE_AVERAGE:  color = 16'((((pa ^ pb) & BLEND_MASK) >> 1) + (pa & pb));
         MODE_SIMPLE:   color = (cur != 0) ? pa : pb;
         default:       color = pa;
      endcase
      addr = row_start + 18'({scan_col, 1'b0});
      // a shrunk size mid-frame ends the line or frame at once
      line_end   = (int'(scan_col) + 1) >= clamp_size(cfg_width);
      frame_done = line_end && ((int'(scan_row) + 1) >= clamp_size(cfg_height));
      wr.addr = addr;
      wr.color = color;
      wr.last = 1'b0;
      wr.frame_end = frame_done;
      pending_writes.push_back(wr);
      wr.addr = addr + 18'd1;
      wr.last = 1'b1;
      pending_writes.push_back(wr);
      if (!line_end) begin
         scan_col = scan_col + 8'd1;
      end else begin
         scan_col = 8'd0;
         if (frame_done) begin
            scan_row = 8'd0;
            row_start = cfg_base;
         end else begin
            scan_row = scan_row + 8'd1;
            row_start = row_start + 18'(cfg_pitch);
         end
      end
   endfunction

   // offer one word, hold it until taken, then update the shadow state
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] cur,
                            input logic [7:0] prev, input logic [15:0] color);
      req_valid <= 1'b1;
      valid_up = 1;
      req_cmd <= cmd;
      req_current_index <= cur;
      req_previous_index <= prev;
      req_entry_color <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (cmd)
         CMD_PAL_WR: begin
            pal_mem[cur] = color;
            if (!pal_written[cur]) begin
               pal_written[cur] = 1;
               pal_used.push_back(cur);
            end
         end
         CMD_BLEND_WR: begin
            if (!blend_mem.exists({cur, prev})) blend_keys.push_back({cur, prev});
            blend_mem[{cur, prev}] = color;
         end
         CMD_PIXEL: predict_pixel(cur, prev);
         default: ; // unused command is dropped by the block
      endcase
   endtask

   task automatic lower_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 0;
      end
   endtask

   // sender bursts: random lengths, random gaps, now and then a long run
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 80);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            lower_valid();
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // block drained: nothing owed, and any table write has left the pipe
   task automatic wait_idle();
      lower_valid();
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // all six registers, written only while the block is idle
   task automatic set_config(input logic [1:0] mode, input logic pv,
                             input logic [8:0] w, input logic [8:0] h,
                             input logic [11:0] pitch, input logic [17:0] base);
      wait_idle();
      csr_write(CSR_FLICKER_MODE, 18'(mode));
      csr_write(CSR_PREVIOUS_VALID, 18'(pv));
      csr_write(CSR_FRAME_WIDTH, 18'(w));
      csr_write(CSR_FRAME_HEIGHT, 18'(h));
      csr_write(CSR_LINE_PITCH, 18'(pitch));
      csr_write(CSR_BASE_ADDRESS, base);
      csr_write_enable <= 1'b0;
      cfg_mode = mode;
      cfg_prev_valid = pv;
      cfg_width = w;
      cfg_height = h;
      cfg_pitch = pitch;
      cfg_base = base;
   endtask

   function automatic logic [7:0] written_index();
      return pal_used[$urandom_range(0, pal_used.size() - 1)];
   endfunction

   // pixel word whose color comes only from written table entries
   task automatic send_pixel_random();
      logic [7:0]  cur;
      logic [7:0]  prev;
      logic [15:0] key;
      prev = 8'($urandom);
      case (cfg_prev_valid ? cfg_mode : MODE_OFF)
         MODE_PHOSPHOR: begin
            key = blend_keys[$urandom_range(0, blend_keys.size() - 1)];
            cur = key[15:8];
            prev = key[7:0];
         end
         MODE_AVERAGE: begin
            cur = written_index();
            prev = written_index();
         end
         MODE_SIMPLE: begin
            // zero current index pulls the previous index color
            cur = ($urandom_range(0, 3) == 0) ? 8'd0 : written_index();
            if (cur == 0) prev = written_index();
         end
         default: cur = written_index();
      endcase
      send_word(CMD_PIXEL, cur, prev, 16'($urandom));
   endtask

   task automatic send_random_word();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 14) begin
         send_word(CMD_PAL_WR, 8'($urandom), 8'($urandom), 16'($urandom));
      end else if (roll < 22) begin
         send_word(CMD_BLEND_WR, 8'($urandom), 8'($urandom), 16'($urandom));
      end else if (roll < 24) begin
         send_word(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
      end else begin
         send_pixel_random();
      end
   endtask

   // extremes of fields, every mode and command, wraps and clamped sizes
   task automatic test_directed();
      send_word(CMD_PAL_WR, 8'h00, 8'h00, 16'hffff);
      send_word(CMD_PAL_WR, 8'hff, 8'hff, 16'h0000);
      send_word(CMD_PAL_WR, 8'h55, 8'h00, 16'haaaa);
      send_word(CMD_PAL_WR, 8'haa, 8'h00, 16'h5555);
      send_word(CMD_BLEND_WR, 8'h00, 8'h00, 16'h1234);
      send_word(CMD_BLEND_WR, 8'hff, 8'hff, 16'hffff);
      send_word(CMD_BLEND_WR, 8'haa, 8'h55, 16'h8001);
      // unused command with every bit set
      send_word(CMD_UNUSED, 8'hff, 8'hff, 16'hffff);
      // reset geometry, block acting as plain lookup
      send_word(CMD_PIXEL, 8'h00, 8'h37, 16'h0000);
      send_word(CMD_PIXEL, 8'hff, 8'h00, 16'h0000);
      send_word(CMD_PIXEL, 8'h55, 8'hff, 16'h0000);
      // zero sizes act as one, base at the top so the pair wraps to zero
      set_config(MODE_PHOSPHOR, 1'b0, 9'd0, 9'd0, 12'd1, 18'h3ffff);
      send_word(CMD_PIXEL, 8'haa, 8'h12, 16'h0000);
      send_word(CMD_PIXEL, 8'h00, 8'h00, 16'h0000);
      set_config(MODE_PHOSPHOR, 1'b1, 9'd0, 9'd0, 12'd1, 18'h3ffff);
      send_word(CMD_PIXEL, 8'h00, 8'h00, 16'h0000);
      send_word(CMD_PIXEL, 8'hff, 8'hff, 16'h0000);
      send_word(CMD_PIXEL, 8'haa, 8'h55, 16'h0000);
      set_config(MODE_AVERAGE, 1'b1, 9'd2, 9'd2, 12'd0, 18'd0);
      send_word(CMD_PIXEL, 8'h00, 8'hff, 16'h0000);
      send_word(CMD_PIXEL, 8'h55, 8'haa, 16'h0000);
      send_word(CMD_PIXEL, 8'h00, 8'h00, 16'h0000);
      set_config(MODE_SIMPLE, 1'b1, 9'd3, 9'd1, 12'd4095, 18'd7);
      send_word(CMD_PIXEL, 8'h00, 8'hff, 16'h0000);
      send_word(CMD_PIXEL, 8'h55, 8'h00, 16'h0000);
      // palette overwrite read back by the very next word
      send_word(CMD_PAL_WR, 8'h55, 8'h00, 16'h0f0f);
      send_word(CMD_PIXEL, 8'h00, 8'h55, 16'h0000);
      // width past the maximum acts as 256
      set_config(MODE_OFF, 1'b1, 9'd300, 9'd1, 12'd0, 18'd0);
      send_word(CMD_PIXEL, 8'hff, 8'h00, 16'h0000);
      send_word(CMD_PIXEL, 8'h00, 8'h00, 16'h0000);
   endtask

   // phases of mixed words, each under its own register setting
   task automatic test_random_phases(input int first, input int count);
      int p;
      for (p = first; p < first + count; p++) begin
         case (p)
            0: set_config(MODE_OFF, 1'b1, 9'd1, 9'd1, 12'd2, 18'd0);
            1: set_config(MODE_PHOSPHOR, 1'b1, 9'd256, 9'd2, 12'd4095, 18'h3ffff);
            2: set_config(MODE_AVERAGE, 1'b1, 9'd511, 9'd511, 12'd0, 18'h20000);
            3: set_config(MODE_SIMPLE, 1'b1, 9'd0, 9'd0, 12'd1, 18'h3fff0);
            4: set_config(MODE_PHOSPHOR, 1'b1, 9'd5, 9'd256, 12'd2048, 18'h3f000);
            default: set_config(2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0,
                                9'($urandom_range(1, 9)), 9'($urandom_range(1, 5)),
                                12'($urandom_range(2, 2048)), 18'($urandom));
         endcase
         repeat (78) begin
            pace();
            send_random_word();
         end
      end
   endtask

   // receiver holds off long while the sender keeps offering, then a full drain
   task automatic test_backpressure();
      set_config(MODE_AVERAGE, 1'b1, 9'd4, 9'd3, 12'd2, 18'd100);
      hold_off_request = 150;
      repeat (40) send_pixel_random();
      wait_idle();
   endtask

   // receiver stall pattern, switching to a randomly picked style after a random run
   initial begin : rsp_stall_gen
      int              hold_left;
      int              style_left;
      stall_style_type style;
      hold_left = 0;
      style_left = 0;
      style = STALL_NONE;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (style_left == 0) begin
            style = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(10, 60);
         end
         style_left--;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            case (style)
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 9) < 7);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // every taken result word against the oldest owed write
   always @(posedge clock) begin : check_words
      fb_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            note_error($sformatf("unexpected word: addr %h color %h last %b end %b",
                                 rsp_write_address, rsp_pixel_color, rsp_last, rsp_frame_end));
         end else begin
            want = pending_writes.pop_front();
            if (rsp_write_address !== want.addr || rsp_pixel_color !== want.color ||
                rsp_last !== want.last || rsp_frame_end !== want.frame_end) begin
               note_error($sformatf(
                  "word mismatch: addr %h/%h color %h/%h last %b/%b end %b/%b (exp/got)",
                  want.addr, rsp_write_address, want.color, rsp_pixel_color,
                  want.last, rsp_last, want.frame_end, rsp_frame_end));
            end
         end
      end
   end

   // hard stop far past the slowest correct run
   initial begin
      #1000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : run_tests
      int drain_cycles;
      // reset values of the registers, scan position at the origin
      cfg_mode = MODE_OFF;
      cfg_prev_valid = 1'b0;
      cfg_width = 9'd160;
      cfg_height = 9'd210;
      cfg_pitch = 12'd512;
      cfg_base = 18'd0;
      scan_col = 8'd0;
      scan_row = 8'd0;
      row_start = 18'd0;
      drain_cycles = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_PIXEL;
      req_current_index <= 8'd0;
      req_previous_index <= 8'd0;
      req_entry_color <= 16'd0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_FLICKER_MODE;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_phases(0, 5);
      test_backpressure();
      test_random_phases(5, 5);

      // bounded drain, then a wait for anything stray
      lower_valid();
      while (pending_writes.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (pending_writes.size() != 0) begin
         note_error($sformatf("%0d owed words never arrived", pending_writes.size()));
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
